[rtl/spq_pkg.sv]
package spq_pkg;

    // default configuration
    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 8;

    // payload field widths
    localparam int PRIO_FIELD_W = 8;
    localparam int TAG_W        = 32;
    localparam int OCC_W        = 5;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic                    op;
        logic [PRIO_FIELD_W-1:0] priority_req;
        logic [TAG_W-1:0]        tag;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [PRIO_FIELD_W-1:0] out_priority;
        logic [TAG_W-1:0]        out_tag;
        logic [OCC_W-1:0]        occupancy;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic insert;
        logic pop;
        logic reject_empty;
        logic reject_full;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } stat_t;

endpackage

[rtl/spq_ctrl.sv]
module spq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  logic           req_op,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    input  spq_pkg::stat_t stat,
    output spq_pkg::cmd_t  cmd
);
    import spq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // a held result blocks a new request only while it is stalled
    assign req_stall = (state_reg == ST_HOLD) && rsp_stall;
    assign rsp_valid = (state_reg == ST_HOLD);
    assign accept    = req_valid && !req_stall;

    // command decode
    always_comb
    begin
        cmd.load         = accept;
        cmd.insert       = accept && (req_op == OP_INSERT) && !stat.full;
        cmd.pop          = accept && (req_op == OP_POP) && !stat.empty;
        cmd.reject_empty = accept && (req_op == OP_POP) && stat.empty;
        cmd.reject_full  = accept && (req_op == OP_INSERT) && stat.full;
    end

    // result register occupancy
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!accept && !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/spq_datapath.sv]
module spq_datapath #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  spq_pkg::req_t  req,
    input  spq_pkg::cmd_t  cmd,
    output spq_pkg::stat_t stat,
    output spq_pkg::rsp_t  rsp
);
    import spq_pkg::*;

    localparam int PB_W  = (PRIO_BITS < PRIO_FIELD_W) ? PRIO_BITS : PRIO_FIELD_W;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // slot 0 holds the entry that pops next, priorities descend with index
    logic [PB_W-1:0]  prio_reg [DEPTH];
    logic [TAG_W-1:0] tag_reg  [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [CNT_W-1:0] cnt_reg;
    rsp_t             rsp_reg;

    logic [PB_W-1:0]  prio_next [DEPTH];
    logic [TAG_W-1:0] tag_next  [DEPTH];
    logic [DEPTH-1:0] vld_next;
    logic [CNT_W-1:0] cnt_next;
    rsp_t             rsp_next;

    logic [PB_W-1:0]  new_prio;
    logic [DEPTH-1:0] after;
    logic [DEPTH-1:0] after_prev;
    logic [PB_W-1:0]  dn_prio [DEPTH];
    logic [TAG_W-1:0] dn_tag  [DEPTH];
    logic [DEPTH-1:0] dn_vld;
    logic [PB_W-1:0]  up_prio [DEPTH];
    logic [TAG_W-1:0] up_tag  [DEPTH];
    logic [DEPTH-1:0] up_vld;

    assign new_prio   = req.priority_req[PB_W-1:0];
    assign stat.empty = !vld_reg[0];
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign rsp        = rsp_reg;

    // neighbor taps of each cell
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_tap
        // new entry goes behind every held entry of strictly greater priority
        assign after[i] = vld_reg[i] && (prio_reg[i] > new_prio);
        if (i == 0)
        begin : g_first
            assign after_prev[i] = 1'b1;
            assign dn_prio[i]    = new_prio;
            assign dn_tag[i]     = req.tag;
            assign dn_vld[i]     = 1'b1;
        end
        else
        begin : g_rest
            assign after_prev[i] = after[i-1];
            assign dn_prio[i]    = prio_reg[i-1];
            assign dn_tag[i]     = tag_reg[i-1];
            assign dn_vld[i]     = vld_reg[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign up_prio[i] = '0;
            assign up_tag[i]  = '0;
            assign up_vld[i]  = 1'b0;
        end
        else
        begin : g_inner
            assign up_prio[i] = prio_reg[i+1];
            assign up_tag[i]  = tag_reg[i+1];
            assign up_vld[i]  = vld_reg[i+1];
        end
    end

    // per-cell next value: hold, take new entry, shift down or shift up
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            prio_next[i] = prio_reg[i];
            tag_next[i]  = tag_reg[i];
            vld_next[i]  = vld_reg[i];
            if (cmd.insert && !after[i])
            begin
                if (after_prev[i])
                begin
                    prio_next[i] = new_prio;
                    tag_next[i]  = req.tag;
                    vld_next[i]  = 1'b1;
                end
                else
                begin
                    prio_next[i] = dn_prio[i];
                    tag_next[i]  = dn_tag[i];
                    vld_next[i]  = dn_vld[i];
                end
            end
            else if (cmd.pop)
            begin
                prio_next[i] = up_prio[i];
                tag_next[i]  = up_tag[i];
                vld_next[i]  = up_vld[i];
            end
        end
    end

    // entry count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.insert)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // result build
    always_comb
    begin
        rsp_next.status       = STS_OK;
        rsp_next.out_priority = '0;
        rsp_next.out_tag      = '0;
        rsp_next.occupancy    = OCC_W'(cnt_next);
        if (cmd.reject_empty)
        begin
            rsp_next.status = STS_EMPTY;
        end
        else if (cmd.reject_full)
        begin
            rsp_next.status = STS_FULL;
        end
        else if (cmd.pop)
        begin
            rsp_next.out_priority = PRIO_FIELD_W'(prio_reg[0]);
            rsp_next.out_tag      = tag_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            prio_reg[i] <= prio_next[i];
            tag_reg[i]  <= tag_next[i];
        end
        if (cmd.load)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

[rtl/sorted_priority_queue.sv]
// Bounded priority queue held as a sorted row of DEPTH entry cells. Each request either
// inserts an entry (priority, tag) or pops the entry of greatest priority; among equal
// priorities the one inserted last pops first. Every request gives exactly one response
// with a status (ok, pop on empty, insert on full which is dropped), the popped entry or
// zeros, and the entry count after the request. A request's response is registered and
// appears in the cycle after the request is taken; a new request is taken every cycle
// unless the held response is stalled. All cells compare against the new priority in
// parallel and shift by one place, so the cells take one request per cycle unless stalled.
// Entries are empty right after reset; no clearing pass is needed.
module sorted_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_op    (req.op),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

    // an accepted request always has its response on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> rsp_valid)
    else $error("accepted request produced no response");

    // a dropped insert is reported only with the queue full
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == STS_FULL)) |-> (rsp.occupancy == OCC_W'(DEPTH)))
    else $error("full status with queue not full");

    // a pop on empty leaves nothing and returns zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == STS_EMPTY)) |->
            ((rsp.occupancy == '0) && (rsp.out_tag == '0) && (rsp.out_priority == '0)))
    else $error("empty status with entries held or nonzero payload");

    // datapath never reports full and empty together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
    else $error("queue flagged full and empty at once");

endmodule
